>>> hw/rtl/c3r_pkg.sv
// Shared types, constants and helpers for the 3x3 per-channel convolution core.
package c3r_pkg;

  // Frame geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);   // column index
  localparam int WID_W      = COL_W + 1;           // width value 1..MAX_WIDTH
  localparam int HGT_W      = 13;                  // height value 1..4096
  localparam int ROW_W      = 13;                  // input row, saturates
  localparam int OROW_W     = 12;                  // output row 0..4095
  localparam logic [ROW_W-1:0] ROW_LIMIT = {ROW_W{1'b1}};

  // Payload widths
  localparam int SAMPLE_W = 16;
  localparam int CHANNELS = 3;
  localparam int PIX_W    = SAMPLE_W * CHANNELS;
  localparam int ENTRY_W  = 2 * PIX_W;             // {older row, newer row}
  localparam int OUT_W    = 15;
  localparam int TAPS     = 9;
  localparam int COEF_N   = CHANNELS * TAPS;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ROWSUM_W = PROD_W + 2;
  localparam int SUM_W    = ROWSUM_W + 2;
  localparam int FRAC_W   = 12;

  // Configuration space
  localparam int CFG_W      = 64;
  localparam int ADDR_W     = 6;
  localparam int COEF_WORDS = 7;
  localparam logic [31:0] FRAME_SIZE_RESET = 32'h0040_0040;

  typedef enum logic [2:0] {
    REG_COEF_0     = 3'd0,
    REG_COEF_1     = 3'd1,
    REG_COEF_2     = 3'd2,
    REG_COEF_3     = 3'd3,
    REG_COEF_4     = 3'd4,
    REG_COEF_5     = 3'd5,
    REG_COEF_6     = 3'd6,
    REG_FRAME_SIZE = 3'd7
  } reg_idx_t;

  typedef logic [TAPS-1:0][PIX_W-1:0]      window_t;
  typedef logic [COEF_N-1:0][SAMPLE_W-1:0] coef_vec_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } border_t;

  typedef struct packed {
    window_t win;
    border_t border;
  } win_item_t;

  // Map the raw width field onto 1..MAX_WIDTH
  function automatic logic [WID_W-1:0] clamp_width(input logic [15:0] raw);
    logic [WID_W-1:0] res;
    if (raw == 16'd0) begin
      res = WID_W'(1);
    end else if (raw > 16'(MAX_WIDTH)) begin
      res = WID_W'(MAX_WIDTH);
    end else begin
      res = raw[WID_W-1:0];
    end
    return res;
  endfunction

  // Map the raw height field onto 1..MAX_HEIGHT
  function automatic logic [HGT_W-1:0] clamp_height(input logic [15:0] raw);
    logic [HGT_W-1:0] res;
    if (raw == 16'd0) begin
      res = HGT_W'(1);
    end else if (raw > 16'(MAX_HEIGHT)) begin
      res = HGT_W'(MAX_HEIGHT);
    end else begin
      res = raw[HGT_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/c3r_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module c3r_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/c3r_window.sv
// Position counters, row store read-modify-write and 3x3 window shifting.
module c3r_window import c3r_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [WID_W-1:0]    frame_w,
  input  logic [HGT_W-1:0]    frame_h,
  input  logic                in_valid,
  input  logic                in_flush,
  input  logic [PIX_W-1:0]    in_pix,
  output logic                in_stall,
  output logic                win_valid,
  output win_item_t           win_item,
  input  logic                win_ready
);

  // Counters
  logic [COL_W-1:0]  in_column, in_column_next;
  logic [ROW_W-1:0]  in_row, in_row_next;
  logic [COL_W-1:0]  out_column, out_column_next;
  logic [OROW_W-1:0] out_row, out_row_next;

  // Entry stage decode
  logic             accept, act, drain0, emit0;
  logic [COL_W-1:0] col0;
  logic [PIX_W-1:0] cur0;
  border_t          border0;

  // Read-data stage
  logic             s1_valid, s1_emit, s1_fire;
  logic [COL_W-1:0] s1_col;
  logic [PIX_W-1:0] s1_cur;
  border_t          s1_border;
  logic             byp_hit;
  logic [ENTRY_W-1:0] byp_data;
  logic [ENTRY_W-1:0] ram_rdata, s1_entry, wr_entry;

  window_t window, window_next;
  logic    out_ready;

  // Decode the incoming transaction against the current position
  always_comb begin
    drain0 = in_row >= ROW_W'(frame_h);
    cur0   = drain0 ? '0 : in_pix;
    col0   = (WID_W'(in_column) < frame_w) ? in_column : COL_W'(frame_w - 1'b1);
    emit0  = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_column != '0));
    border0.top    = out_row == '0;
    border0.bottom = HGT_W'(out_row) >= (frame_h - 1'b1);
    border0.left   = out_column == '0;
    border0.right  = WID_W'(out_column) >= (frame_w - 1'b1);
    border0.last   = border0.bottom && border0.right;
  end

  assign out_ready = !win_valid || win_ready;
  assign s1_fire   = s1_valid && (!s1_emit || out_ready);
  assign in_stall  = s1_valid && !s1_fire;
  assign accept    = in_valid && !in_stall;
  assign act       = accept && !(in_flush && !drain0);

  // Advance the position counters
  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (act) begin
      if ((WID_W'(in_column) + 1'b1) >= frame_w) begin
        in_column_next = '0;
        if (in_row != ROW_LIMIT) begin
          in_row_next = in_row + 1'b1;
        end
      end else begin
        in_column_next = in_column + 1'b1;
      end
      if (emit0) begin
        if (border0.last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (border0.right) begin
          out_column_next = '0;
          out_row_next    = out_row + 1'b1;
        end else begin
          out_column_next = out_column + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // Row store: one entry per column holds {older row, newer row}
  c3r_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (wr_entry),
    .re    (act),
    .raddr (col0),
    .rdata (ram_rdata)
  );

  // Forward a write that lands on the edge the same column is read
  assign s1_entry = byp_hit ? byp_data : ram_rdata;
  assign wr_entry = {s1_entry[PIX_W-1:0], s1_cur};

  always_ff @(posedge clk) begin
    if (act) begin
      byp_hit  <= s1_fire && (s1_col == col0);
      byp_data <= wr_entry;
    end
  end

  // Load the read-data stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (act) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      s1_col    <= col0;
      s1_cur    <= cur0;
      s1_emit   <= emit0;
      s1_border <= border0;
    end
  end

  // Shift the window by one column and bring in the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[r*3]     = window[r*3 + 1];
      window_next[r*3 + 1] = window[r*3 + 2];
    end
    window_next[2] = s1_entry[ENTRY_W-1:PIX_W];
    window_next[5] = s1_entry[PIX_W-1:0];
    window_next[8] = s1_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_fire) begin
      window <= window_next;
    end
  end

  // Hand the window to the arithmetic when this transaction emits
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      win_valid <= 1'b1;
    end else if (win_ready) begin
      win_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      win_item.win    <= window_next;
      win_item.border <= s1_border;
    end
  end

  // A read issued on one edge is always followed by a loaded stage
  a_read_loads_stage: assert property (@(posedge clk) disable iff (rst)
    $past(act) && !$past(rst) |-> s1_valid)
    else $error("row store read without a loaded stage");

  // A window waiting for the arithmetic keeps its contents
  a_win_hold: assert property (@(posedge clk) disable iff (rst)
    win_valid && !win_ready |=> win_valid && $stable(win_item))
    else $error("waiting window changed");

  // The frame end brings all position counters back to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    act && emit0 && border0.last |=>
      (in_column == '0) && (in_row == '0) && (out_column == '0) && (out_row == '0))
    else $error("counters not cleared at frame end");

  // A stalled stage keeps its column
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_col))
    else $error("stalled stage lost its column");

endmodule

>>> hw/rtl/c3r_mac.sv
// Masked products, row sums, ReLU and saturation for the three channels.
module c3r_mac import c3r_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  coef_vec_t         coefs,
  input  logic              win_valid,
  input  win_item_t         win_item,
  output logic              win_ready,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [OUT_W-1:0]  res_r,
  output logic [OUT_W-1:0]  res_g,
  output logic [OUT_W-1:0]  res_b,
  output logic              res_last
);

  // Product stage
  logic                       s3_valid, s3_last, s3_ready;
  logic signed [PROD_W-1:0]   prod [CHANNELS][TAPS];
  logic signed [PROD_W-1:0]   prod_next [CHANNELS][TAPS];

  // Row-sum stage
  logic                       s4_valid, s4_last, s4_ready;
  logic signed [ROWSUM_W-1:0] rowsum [CHANNELS][3];
  logic signed [ROWSUM_W-1:0] rowsum_next [CHANNELS][3];

  // Output stage
  logic                       res_ready;
  logic signed [SUM_W-1:0]    total [CHANNELS];
  logic [OUT_W-1:0]           clipped [CHANNELS];
  logic [SUM_W-FRAC_W-1:0]    shifted [CHANNELS];

  assign res_ready = !res_valid || !res_stall;
  assign s4_ready  = !s4_valid || res_ready;
  assign s3_ready  = !s3_valid || s4_ready;
  assign win_ready = s3_ready;

  // Multiply each tap by its coefficient, drop taps outside the frame
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r == 0 && win_item.border.top) || (r == 2 && win_item.border.bottom) ||
              (c == 0 && win_item.border.left) || (c == 2 && win_item.border.right)) begin
            prod_next[ch][r*3 + c] = '0;
          end else begin
            prod_next[ch][r*3 + c] =
              $signed(win_item.win[r*3 + c][ch*SAMPLE_W +: SAMPLE_W]) *
              $signed(coefs[ch*TAPS + r*3 + c]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && win_valid) begin
      prod    <= prod_next;
      s3_last <= win_item.border.last;
    end
  end

  // Sum each window row
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int r = 0; r < 3; r++) begin
        rowsum_next[ch][r] = ROWSUM_W'(prod[ch][r*3]) + ROWSUM_W'(prod[ch][r*3 + 1]) +
                             ROWSUM_W'(prod[ch][r*3 + 2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      rowsum  <= rowsum_next;
      s4_last <= s3_last;
    end
  end

  // Total, ReLU, drop the fraction and saturate
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      total[ch] = SUM_W'(rowsum[ch][0]) + SUM_W'(rowsum[ch][1]) + SUM_W'(rowsum[ch][2]);
      shifted[ch] = total[ch][SUM_W-1:FRAC_W];
      if (total[ch] <= 0) begin
        clipped[ch] = '0;
      end else if (shifted[ch] > (SUM_W-FRAC_W)'({OUT_W{1'b1}})) begin
        clipped[ch] = {OUT_W{1'b1}};
      end else begin
        clipped[ch] = shifted[ch][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && s4_valid) begin
      res_r    <= clipped[0];
      res_g    <= clipped[1];
      res_b    <= clipped[2];
      res_last <= s4_last;
    end
  end

  // Blocked product stage keeps its transaction
  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !s4_ready |=> s3_valid && $stable(s3_last))
    else $error("product stage dropped a blocked transaction");

  // Blocked row-sum stage keeps its transaction
  a_s4_hold: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !res_ready |=> s4_valid && $stable(s4_last))
    else $error("row-sum stage dropped a blocked transaction");

endmodule

>>> hw/rtl/conv3x3_relu_per_channel_core.sv
// Top level: configuration registers, window front end and arithmetic pipeline.
//
//  Channel   Handshake                      Payload
//  sample    sample_valid / sample_stall    sample_r, sample_g, sample_b, flush
//  result    result_valid / result_stall    out_r, out_g, out_b, frame_last
//  config    psel / penable / pready        paddr, pwrite, pwdata, prdata
//
// One transaction per cycle while sample_stall is low; the sample that emits a result passes
// the read-data stage, window register, product and row-sum stages and output register.
// The rate is set by the row store: one read and one write-back per transaction, with a
// forward path for a column read on the same edge it is written.
// Reset clears counters, window and pipeline valids; the row store needs no clearing pass.
// A stall on the result channel backs up the pipeline stage by stage to sample_stall.
module conv3x3_relu_per_channel_core import c3r_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [CFG_W-1:0]    pwdata,
  output logic [CFG_W-1:0]    prdata,
  output logic                pready,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample_r,
  input  logic signed [SAMPLE_W-1:0] sample_g,
  input  logic signed [SAMPLE_W-1:0] sample_b,
  input  logic                flush,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [OUT_W-1:0]    out_r,
  output logic [OUT_W-1:0]    out_g,
  output logic [OUT_W-1:0]    out_b,
  output logic                frame_last
);

  logic [CFG_W-1:0] coef_word [COEF_WORDS];
  logic [31:0]      frame_size;
  reg_idx_t         reg_idx;
  logic             cfg_write;
  coef_vec_t        coefs;
  logic [WID_W-1:0] frame_w;
  logic [HGT_W-1:0] frame_h;

  logic      win_valid, win_ready;
  win_item_t win_item;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_WORDS; i++) begin
        coef_word[i] <= '0;
      end
      frame_size <= FRAME_SIZE_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_COEF_0:     coef_word[0] <= pwdata;
        REG_COEF_1:     coef_word[1] <= pwdata;
        REG_COEF_2:     coef_word[2] <= pwdata;
        REG_COEF_3:     coef_word[3] <= pwdata;
        REG_COEF_4:     coef_word[4] <= pwdata;
        REG_COEF_5:     coef_word[5] <= pwdata;
        REG_COEF_6:     coef_word[6] <= pwdata;
        REG_FRAME_SIZE: frame_size   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_COEF_0:     prdata = coef_word[0];
      REG_COEF_1:     prdata = coef_word[1];
      REG_COEF_2:     prdata = coef_word[2];
      REG_COEF_3:     prdata = coef_word[3];
      REG_COEF_4:     prdata = coef_word[4];
      REG_COEF_5:     prdata = coef_word[5];
      REG_COEF_6:     prdata = coef_word[6];
      REG_FRAME_SIZE: prdata = CFG_W'(frame_size);
      default:        prdata = '0;
    endcase
  end

  // Unpack the 27 coefficients, four to a word
  always_comb begin
    for (int k = 0; k < COEF_N; k++) begin
      coefs[k] = coef_word[k >> 2][(k & 3)*SAMPLE_W +: SAMPLE_W];
    end
  end

  assign frame_w = clamp_width(frame_size[15:0]);
  assign frame_h = clamp_height(frame_size[31:16]);

  c3r_window u_window (
    .clk       (clk),
    .rst       (rst),
    .frame_w   (frame_w),
    .frame_h   (frame_h),
    .in_valid  (sample_valid),
    .in_flush  (flush),
    .in_pix    ({sample_b, sample_g, sample_r}),
    .in_stall  (sample_stall),
    .win_valid (win_valid),
    .win_item  (win_item),
    .win_ready (win_ready)
  );

  c3r_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .coefs     (coefs),
    .win_valid (win_valid),
    .win_item  (win_item),
    .win_ready (win_ready),
    .res_valid (result_valid),
    .res_stall (result_stall),
    .res_r     (out_r),
    .res_g     (out_g),
    .res_b     (out_b),
    .res_last  (frame_last)
  );

endmodule

>>> tb/sv/conv3x3_relu_per_channel_core_tb.sv
// Self-checking testbench for the 3x3 per-channel convolution core with ReLU.
module conv3x3_relu_per_channel_core_tb;
  import c3r_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam longint TIMEOUT   = 64'd20 * 64'd600000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] r;
    logic signed [SAMPLE_W-1:0] g;
    logic signed [SAMPLE_W-1:0] b;
    logic                       flush;
  } sample_t;

  typedef struct packed {
    logic [OUT_W-1:0] r;
    logic [OUT_W-1:0] g;
    logic [OUT_W-1:0] b;
    logic             last;
  } pixel_t;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    reg_idx_t         idx;
    logic [CFG_W-1:0] value;
    sample_t          item;
    logic             checked;
    pixel_t           want;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [CFG_W-1:0]           pwdata = '0;
  logic [CFG_W-1:0]           prdata;
  logic                       pready;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample_r = '0;
  logic signed [SAMPLE_W-1:0] sample_g = '0;
  logic signed [SAMPLE_W-1:0] sample_b = '0;
  logic                       flush = 1'b0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [OUT_W-1:0]           out_r;
  logic [OUT_W-1:0]           out_g;
  logic [OUT_W-1:0]           out_b;
  logic                       frame_last;

  // Shadow of the block: registers, row stores, window and position counters
  logic [CFG_W-1:0] coef_word [COEF_WORDS];
  logic [31:0]      frame_size_q;
  logic [PIX_W-1:0] older_row [MAX_WIDTH];
  logic [PIX_W-1:0] newer_row [MAX_WIDTH];
  logic [PIX_W-1:0] tap_window [TAPS];
  int unsigned      in_col, in_row, out_col, out_row;
  pixel_t           expected_pixels [$];

  int fail_count    = 0;
  int tx_pct        = 0;
  int rx_pct        = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  conv3x3_relu_per_channel_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_r     (sample_r),
    .sample_g     (sample_g),
    .sample_b     (sample_b),
    .flush        (flush),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_r        (out_r),
    .out_g        (out_g),
    .out_b        (out_b),
    .frame_last   (frame_last)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int unsigned cur_width();
    int unsigned w;
    w = frame_size_q[15:0];
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned cur_height();
    int unsigned h;
    h = frame_size_q[31:16];
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic longint lane(input logic [PIX_W-1:0] v, input int ch);
    return longint'($signed(v[SAMPLE_W*ch +: SAMPLE_W]));
  endfunction

  function automatic longint coef_of(input int k);
    logic [CFG_W-1:0] word;
    word = coef_word[k/4];
    return longint'($signed(word[SAMPLE_W*(k%4) +: SAMPLE_W]));
  endfunction

  // Advance the shadow by one accepted transaction; report the pixel it emits
  task automatic window_predict(input sample_t s, output bit emitted, output pixel_t px);
    int unsigned      w, h, col;
    logic [PIX_W-1:0] cur;
    bit               drain, top, bottom, left, right;
    longint           acc;
    logic [OUT_W-1:0] ch_out [CHANNELS];
    w = cur_width();
    h = cur_height();
    drain = in_row >= h;
    emitted = 1'b0;
    px = '0;
    // drop a flush that arrives inside the frame
    if (s.flush && !drain) return;
    cur = drain ? '0 : {s.b, s.g, s.r};
    col = (in_col < w) ? in_col : w - 1;
    for (int row = 0; row < 3; row++) begin
      tap_window[row*3]   = tap_window[row*3+1];
      tap_window[row*3+1] = tap_window[row*3+2];
    end
    tap_window[2] = older_row[col];
    tap_window[5] = newer_row[col];
    tap_window[8] = cur;
    older_row[col] = newer_row[col];
    newer_row[col] = cur;
    emitted = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row < ROW_LIMIT) in_row++;
    end else begin
      in_col++;
    end
    if (!emitted) return;
    top    = out_row == 0;
    bottom = out_row >= h - 1;
    left   = out_col == 0;
    right  = out_col >= w - 1;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      acc = 0;
      for (int row = 0; row < 3; row++) begin
        if ((row == 0 && top) || (row == 2 && bottom)) continue;
        for (int cc = 0; cc < 3; cc++) begin
          if ((cc == 0 && left) || (cc == 2 && right)) continue;
          acc += lane(tap_window[row*3+cc], ch) * coef_of(ch*TAPS + row*3 + cc);
        end
      end
      // ReLU, then scale back from the Q3.12 coefficient format to whole samples and saturate
      if (acc <= 0) ch_out[ch] = '0;
      else if ((acc >>> FRAC_W) > 32767) ch_out[ch] = '1;
      else ch_out[ch] = OUT_W'(acc >>> FRAC_W);
    end
    px.r = ch_out[0];
    px.g = ch_out[1];
    px.b = ch_out[2];
    px.last = bottom && right;
    if (px.last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_lane(input int unsigned scale);
    logic [SAMPLE_W-1:0] v;
    case (scale)
      0: v = SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(5))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h0000;
          3: v = 16'hFFFF;
          4: v = 16'h0001;
          default: v = SAMPLE_W'($urandom);
        endcase
      end
      default: v = SAMPLE_W'(int'($urandom_range(8191)) - 4096);
    endcase
    return v;
  endfunction

  function automatic sample_t random_sample(input int unsigned scale);
    sample_t s;
    s.r = rand_lane(scale);
    s.g = rand_lane(scale);
    s.b = rand_lane(scale);
    s.flush = 1'b0;
    return s;
  endfunction

  function automatic stim_row_t write_row(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.value = value;
    return row;
  endfunction

  function automatic stim_row_t item_row(input int r, input int g, input int b, input bit fl,
                                         input bit chk, input pixel_t want);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item.r = SAMPLE_W'(r);
    row.item.g = SAMPLE_W'(g);
    row.item.b = SAMPLE_W'(b);
    row.item.flush = fl;
    row.checked = chk;
    row.want = want;
    return row;
  endfunction

  // Offer one transaction, hold it until taken, then predict its result
  task automatic send_item(input sample_t s, input bit use_want, input pixel_t want);
    bit     emitted;
    pixel_t px;
    if ($urandom_range(99) < tx_pct) begin
      sample_valid <= 1'b0;
      sample_r <= SAMPLE_W'($urandom);
      sample_g <= SAMPLE_W'($urandom);
      sample_b <= SAMPLE_W'($urandom);
      flush <= 1'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < tx_pct) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_r <= s.r;
    sample_g <= s.g;
    sample_b <= s.b;
    flush <= s.flush;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    window_predict(s, emitted, px);
    if (emitted) expected_pixels.push_back(use_want ? want : px);
  endtask

  // Stop offering and let every pending result come out
  task automatic settle();
    sample_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; update the shadow once the write lands
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(8 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_FRAME_SIZE) frame_size_q = value[31:0];
    else coef_word[idx] = value;
    @(posedge clk);
  endtask

  // One whole frame: pixels with stray flushes, then the drain transactions
  task automatic send_frame(input bit pause_mid, output int count);
    int unsigned w, h, n, scale;
    sample_t     s;
    w = cur_width();
    h = cur_height();
    scale = $urandom_range(3);
    n = 0;
    count = 0;
    while (n < w * h) begin
      s = random_sample(scale);
      if ($urandom_range(15) == 0) begin
        s.flush = 1'b1;
        send_item(s, 1'b0, '0);
      end else begin
        send_item(s, 1'b0, '0);
        n++;
        count++;
        if (pause_mid && n == (w * h) / 2) settle();
      end
    end
    repeat (w + 1) begin
      s = random_sample(scale);
      s.flush = ($urandom_range(3) != 0);
      send_item(s, 1'b0, '0);
      count++;
    end
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Result side: check each transaction, stall at random or for a long hold
  always @(posedge clk) begin : result_side
    pixel_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result r=%0d g=%0d b=%0d last=%0d", out_r, out_g, out_b, frame_last);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_r", want.r, out_r);
        check_field("out_g", want.g, out_g);
        check_field("out_b", want.b, out_b);
        check_field("frame_last", want.last, frame_last);
      end
    end
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  initial begin : stimulus
    stim_row_t   rows [$];
    int          random_items, phase, frames, count;
    bit          pending_items;
    logic [15:0] w_raw, h_raw;
    int unsigned coef_scale;
    logic [CFG_W-1:0] word;

    // Reset state of the shadow
    foreach (coef_word[i]) coef_word[i] = '0;
    frame_size_q = FRAME_SIZE_RESET;
    foreach (older_row[i]) older_row[i] = '0;
    foreach (newer_row[i]) newer_row[i] = '0;
    foreach (tap_window[i]) tap_window[i] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: red identity, green all +max, blue all -max
    rows.push_back(write_row(REG_COEF_0, 64'h0000_0000_0000_0000));
    rows.push_back(write_row(REG_COEF_1, 64'h0000_0000_0000_1000));
    rows.push_back(write_row(REG_COEF_2, 64'h7FFF_7FFF_7FFF_0000));
    rows.push_back(write_row(REG_COEF_3, 64'h7FFF_7FFF_7FFF_7FFF));
    rows.push_back(write_row(REG_COEF_4, 64'h8000_8000_7FFF_7FFF));
    rows.push_back(write_row(REG_COEF_5, 64'h8000_8000_8000_8000));
    rows.push_back(write_row(REG_COEF_6, 64'hFFFF_8000_8000_8000));
    // 2x2 frame: every window covers the whole frame
    rows.push_back(write_row(REG_FRAME_SIZE, 64'h0000_0000_0002_0002));
    rows.push_back(item_row(32767, 32767, -32768, 1'b0, 1'b0, '0));
    rows.push_back(item_row(-32768, -32768, 32767, 1'b0, 1'b0, '0));
    rows.push_back(item_row(0, 0, 0, 1'b1, 1'b0, '0));
    rows.push_back(item_row(1, 0, 0, 1'b0, 1'b0, '0));
    rows.push_back(item_row(4660, 1, -1, 1'b0, 1'b1, '{15'd32767, 15'd0, 15'd16, 1'b0}));
    rows.push_back(item_row(-1, -1, -1, 1'b0, 1'b1, '{15'd0, 15'd0, 15'd16, 1'b0}));
    rows.push_back(item_row(0, 0, 0, 1'b1, 1'b1, '{15'd1, 15'd0, 15'd16, 1'b0}));
    rows.push_back(item_row(0, 0, 0, 1'b1, 1'b1, '{15'd4660, 15'd0, 15'd16, 1'b1}));
    // zero width and height act as a 1x1 frame; results saturate
    rows.push_back(write_row(REG_FRAME_SIZE, 64'h0000_0000_0000_0000));
    rows.push_back(item_row(0, 0, 0, 1'b1, 1'b0, '0));
    rows.push_back(item_row(32767, 32767, -32768, 1'b0, 1'b0, '0));
    rows.push_back(item_row(0, 0, 0, 1'b1, 1'b0, '0));
    rows.push_back(item_row(-32768, 32767, 1, 1'b0, 1'b1,
                            '{15'd32767, 15'd32767, 15'd32767, 1'b1}));

    tx_pct = 26;
    rx_pct = 54;
    pending_items = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        if (pending_items) settle();
        pending_items = 1'b0;
        write_reg(rows[i].idx, rows[i].value);
      end else begin
        pending_items = 1'b1;
        send_item(rows[i].item, rows[i].checked, rows[i].want);
      end
    end

    // Random phases: new coefficients and frame size, then whole frames
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items < RANDOM_ITEMS / 3) begin
        tx_pct = 26;
        rx_pct = 54;
      end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
        tx_pct = 54;
        rx_pct = 26;
      end else begin
        tx_pct = 0;
        rx_pct = 0;
      end
      settle();
      coef_scale = $urandom_range(3);
      for (int k = 0; k < COEF_WORDS; k++) begin
        for (int ln = 0; ln < 4; ln++) word[SAMPLE_W*ln +: SAMPLE_W] = rand_lane(coef_scale);
        write_reg(reg_idx_t'(k), word);
      end
      frames = $urandom_range(1, 3);
      case (phase)
        2: begin
          w_raw = 16'd1;
          h_raw = 16'd6;
        end
        3: begin
          w_raw = 16'd12;
          h_raw = 16'd4;
        end
        5: begin
          w_raw = 16'd40;
          h_raw = 16'd1;
        end
        default: begin
          w_raw = ($urandom_range(9) == 0) ? 16'd0 :
                  16'($urandom_range(1, ($urandom_range(4) == 0) ? 40 : 8));
          h_raw = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        end
      endcase
      write_reg(REG_FRAME_SIZE, {32'($urandom), h_raw, w_raw});
      // hold the result side off long enough to back the block up
      if (phase == 3) hold_requests++;
      repeat (frames) begin
        send_frame(phase == 1, count);
        random_items += count;
      end
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("** conv3x3_relu_per_channel_core: PASSED **");
    end else begin
      $display("** conv3x3_relu_per_channel_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("** conv3x3_relu_per_channel_core: FAILED **");
    $finish;
  end

endmodule
